// ===== rtl/sjsc_pkg.sv =====
// shared types and constants of the servo jog and suction controller
`default_nettype none

package sjsc_pkg;

    localparam int ANGLE_W   = 18;
    localparam int GAIN_W    = 10;
    localparam int HOLD_W    = 16;
    localparam int TIME_W    = 32;
    localparam int JOY_W     = 16;
    localparam int DELTA_W   = 26;
    localparam int PULSE_W   = 8;
    localparam int SEL_W     = 3;
    localparam int NUM_PULSES = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 18'd180000;
    localparam logic [ANGLE_W-1:0] PULSE_DIV = 18'd900;
    localparam logic [PULSE_W-1:0] PULSE_BASE = 8'd50;

    // floor(a / 900) == (a * 149131) >> 27 for every a up to full scale
    localparam logic [ANGLE_W-1:0] PULSE_RECIP = 18'd149131;
    localparam int                 PULSE_SHIFT = 27;

    localparam logic [SEL_W-1:0] SEL_NONE     = 3'd4;
    localparam logic [SEL_W-1:0] SEL_REVERSED = 3'd2;
    localparam logic [1:0]       MODE_JOG     = 2'd1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JOG_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS  = 3'd6;

    // reset values of the registers
    localparam logic [ANGLE_W-1:0] RST_PRESET_A = 18'd90000;
    localparam logic [ANGLE_W-1:0] RST_PRESET_B = 18'd31000;
    localparam logic [ANGLE_W-1:0] RST_PRESET_C = 18'd64000;
    localparam logic [ANGLE_W-1:0] RST_PRESET_D = 18'd95000;
    localparam logic [ANGLE_W-1:0] RST_STARTUP  = 18'd90000;
    localparam logic [GAIN_W-1:0]  RST_JOG_GAIN = 10'd3;
    localparam logic [HOLD_W-1:0]  RST_HOLD_MS  = 16'd500;

    typedef struct packed {
        logic [NUM_PULSES-1:0][ANGLE_W-1:0] preset_angle;
        logic [ANGLE_W-1:0]                 startup_angle;
        logic [HOLD_W-1:0]                  release_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]         now_ms;
        logic signed [DELTA_W-1:0] jog_delta;
        logic [1:0]                mode;
        logic [3:0]                buttons;
        logic                      suction_switch;
        logic                      preset_switch;
    } tick_t;

    typedef struct packed {
        logic [NUM_PULSES-1:0][ANGLE_W-1:0] angle;
        logic                               pump_on;
        logic                               valve_open;
        logic [SEL_W-1:0]                   servo_sel;
        logic                               suction_flag;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sjsc_core.sv =====
// per-tick state update: priming, preset, selection, jog and suction control
`default_nettype none

module sjsc_core #(
    parameter int NUM_SERVOS = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tick_valid,
    input  wire sjsc_pkg::tick_t tick,
    input  wire sjsc_pkg::cfg_t  cfg,
    output logic                 tick_ready,
    input  wire logic            mid_ready,
    output logic                 mid_valid,
    output sjsc_pkg::result_t    mid
);
    import sjsc_pkg::*;

    localparam int ACTIVE = (NUM_SERVOS < NUM_PULSES) ? NUM_SERVOS : NUM_PULSES;

    logic [ANGLE_W-1:0] angle_reg [ACTIVE];
    logic [ANGLE_W-1:0] angle_next [ACTIVE];
    logic               prev_suction_reg, prev_suction_next;
    logic               prev_preset_reg, prev_preset_next;
    logic               primed_reg;
    logic               releasing_reg, releasing_next;
    logic [TIME_W-1:0]  release_start_reg, release_start_next;
    logic               pump_reg, pump_next;
    logic               valve_reg, valve_next;
    logic               suction_reg, suction_next;
    logic               mid_valid_reg;
    result_t            mid_reg, mid_next;

    logic [SEL_W-1:0]          sel;
    logic [ANGLE_W-1:0]        sel_angle;
    logic [ANGLE_W-1:0]        jog_angle;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W:0]   sum;
    logic                      prev_p;
    logic                      prev_s;
    logic [TIME_W-1:0]         elapsed;
    logic                      advance;

    assign advance    = tick_valid && tick_ready;
    assign tick_ready = !mid_valid_reg || mid_ready;

    always_comb
    begin
        // first tick: startup angles, previous switches follow this tick
        for (int i = 0; i < ACTIVE; i++)
        begin
            angle_next[i] = primed_reg ? angle_reg[i] : cfg.startup_angle;
        end
        prev_p = primed_reg ? prev_preset_reg : tick.preset_switch;
        prev_s = primed_reg ? prev_suction_reg : tick.suction_switch;

        if (tick.preset_switch && !prev_p)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                angle_next[i] = cfg.preset_angle[i];
            end
        end
        prev_preset_next = tick.preset_switch;

        // lowest pressed button wins
        sel = SEL_NONE;
        for (int i = ACTIVE - 1; i >= 0; i--)
        begin
            if (tick.buttons[i])
            begin
                sel = SEL_W'(i);
            end
        end

        sel_angle = '0;
        for (int i = 0; i < ACTIVE; i++)
        begin
            if (sel == SEL_W'(i))
            begin
                sel_angle = angle_next[i];
            end
        end

        delta = (sel == SEL_REVERSED) ? -tick.jog_delta : tick.jog_delta;
        sum   = $signed({{(DELTA_W + 1 - ANGLE_W){1'b0}}, sel_angle}) + (DELTA_W + 1)'(delta);
        if (sum < 0)
        begin
            jog_angle = '0;
        end
        else if (sum > $signed({{(DELTA_W + 1 - ANGLE_W){1'b0}}, ANGLE_MAX}))
        begin
            jog_angle = ANGLE_MAX;
        end
        else
        begin
            jog_angle = sum[ANGLE_W-1:0];
        end

        if (tick.mode == MODE_JOG)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                if (sel == SEL_W'(i))
                begin
                    angle_next[i] = jog_angle;
                end
            end
        end

        // suction switch change
        pump_next          = pump_reg;
        valve_next         = valve_reg;
        releasing_next     = releasing_reg;
        release_start_next = release_start_reg;
        suction_next       = suction_reg;
        if (tick.suction_switch != prev_s)
        begin
            if (tick.suction_switch)
            begin
                valve_next     = 1'b0;
                pump_next      = 1'b1;
                releasing_next = 1'b0;
                suction_next   = 1'b1;
            end
            else
            begin
                pump_next          = 1'b0;
                valve_next         = 1'b1;
                releasing_next     = 1'b1;
                release_start_next = tick.now_ms;
                suction_next       = 1'b0;
            end
        end
        prev_suction_next = tick.suction_switch;

        // valve closes itself once the hold time has passed
        elapsed = tick.now_ms - release_start_next;
        if (releasing_next && (elapsed > {{(TIME_W - HOLD_W){1'b0}}, cfg.release_hold_ms}))
        begin
            valve_next     = 1'b0;
            releasing_next = 1'b0;
        end

        mid_next = '0;
        for (int i = 0; i < ACTIVE; i++)
        begin
            mid_next.angle[i] = angle_next[i];
        end
        mid_next.pump_on      = pump_next;
        mid_next.valve_open   = valve_next;
        mid_next.servo_sel    = sel;
        mid_next.suction_flag = suction_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                angle_reg[i] <= RST_STARTUP;
            end
            prev_suction_reg  <= 1'b0;
            prev_preset_reg   <= 1'b0;
            primed_reg        <= 1'b0;
            releasing_reg     <= 1'b0;
            release_start_reg <= '0;
            pump_reg          <= 1'b0;
            valve_reg         <= 1'b0;
            suction_reg       <= 1'b0;
            mid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (tick_ready)
            begin
                mid_valid_reg <= tick_valid;
            end
            if (advance)
            begin
                for (int i = 0; i < ACTIVE; i++)
                begin
                    angle_reg[i] <= angle_next[i];
                end
                prev_suction_reg  <= prev_suction_next;
                prev_preset_reg   <= prev_preset_next;
                primed_reg        <= 1'b1;
                releasing_reg     <= releasing_next;
                release_start_reg <= release_start_next;
                pump_reg          <= pump_next;
                valve_reg         <= valve_next;
                suction_reg       <= suction_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

`default_nettype wire

// ===== rtl/sjsc_pulse.sv =====
// angle to timer compare conversion and the result register
`default_nettype none

module sjsc_pulse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              mid_valid,
    input  wire sjsc_pkg::result_t mid,
    output logic                   mid_ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             pulse_a,
    output logic [7:0]             pulse_b,
    output logic [7:0]             pulse_c,
    output logic [7:0]             pulse_d,
    output logic                   pump_on,
    output logic                   valve_open,
    output logic [2:0]             servo_sel,
    output logic                   suction_flag
);
    import sjsc_pkg::*;

    logic                               out_valid_reg;
    logic [NUM_PULSES-1:0][PULSE_W-1:0] pulse_reg, pulse_next;
    logic                               pump_reg;
    logic                               valve_reg;
    logic [SEL_W-1:0]                   sel_reg;
    logic                               suction_reg;

    // clamp, divide by 900 through a reciprocal multiply, exact up to full scale, and add the base
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-1:0]   a;
        logic [2*ANGLE_W-1:0] prod;
        a    = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
        prod = a * PULSE_RECIP;
        return PULSE_BASE + prod[PULSE_SHIFT+PULSE_W-1:PULSE_SHIFT];
    endfunction

    assign mid_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        for (int i = 0; i < NUM_PULSES; i++)
        begin
            pulse_next[i] = pulse_of(mid.angle[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_ready && mid_valid)
        begin
            pulse_reg   <= pulse_next;
            pump_reg    <= mid.pump_on;
            valve_reg   <= mid.valve_open;
            sel_reg     <= mid.servo_sel;
            suction_reg <= mid.suction_flag;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pulse_a      = pulse_reg[0];
    assign pulse_b      = pulse_reg[1];
    assign pulse_c      = pulse_reg[2];
    assign pulse_d      = pulse_reg[3];
    assign pump_on      = pump_reg;
    assign valve_open   = valve_reg;
    assign servo_sel    = sel_reg;
    assign suction_flag = suction_reg;

endmodule

`default_nettype wire

// ===== rtl/servo_jog_and_suction_controller.sv =====
// top level of the servo jog and suction controller
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   now_ms joystick mode buttons suction_switch
//                                            preset_switch
// out       output     out_valid / out_stall pulse_a..pulse_d pump_on valve_open
//                                            servo_sel suction_flag
// cfg       input      cfg_wen               cfg_addr cfg_wdata, no read-back
//
// one item per cycle while out_stall is low; an accepted item passes through the
// input register, the state update stage and the compare-value stage, in that
// order, before its result is on the outputs
// the state update stage reads the servo state and writes its update back as
// each item advances, so each item sees everything left by the one before it
// a stall on the output ripples back through the three stages to in_stall
// reset clears the pipeline, the servo state and puts registers at defaults
`default_nettype none

module servo_jog_and_suction_controller #(
    parameter int NUM_SERVOS = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // item input
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [31:0]                    now_ms,
    input  wire logic signed [15:0]             joystick,
    input  wire logic [1:0]                     mode,
    input  wire logic [3:0]                     buttons,
    input  wire logic                           suction_switch,
    input  wire logic                           preset_switch,
    // item output
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          pulse_a,
    output logic [7:0]                          pulse_b,
    output logic [7:0]                          pulse_c,
    output logic [7:0]                          pulse_d,
    output logic                                pump_on,
    output logic                                valve_open,
    output logic [2:0]                          servo_sel,
    output logic                                suction_flag,
    // configuration writes
    input  wire logic                           cfg_wen,
    input  wire logic [sjsc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [sjsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sjsc_pkg::*;

    // configuration registers
    logic [NUM_PULSES-1:0][ANGLE_W-1:0] preset_reg;
    logic [ANGLE_W-1:0]                 startup_reg;
    logic [GAIN_W-1:0]                  gain_reg;
    logic [HOLD_W-1:0]                  hold_reg;
    cfg_t                               cfg;

    // input register
    logic                        s0_valid_reg;
    tick_t                       s0_reg;
    tick_t                       s0_next;
    logic                        s0_ready;
    logic signed [DELTA_W:0]     product;

    // between the state stage and the compare stage
    logic    mid_valid;
    logic    mid_ready;
    result_t mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg[0] <= RST_PRESET_A;
            preset_reg[1] <= RST_PRESET_B;
            preset_reg[2] <= RST_PRESET_C;
            preset_reg[3] <= RST_PRESET_D;
            startup_reg   <= RST_STARTUP;
            gain_reg      <= RST_JOG_GAIN;
            hold_reg      <= RST_HOLD_MS;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_PRESET_A: preset_reg[0] <= cfg_wdata[ANGLE_W-1:0];
                REG_PRESET_B: preset_reg[1] <= cfg_wdata[ANGLE_W-1:0];
                REG_PRESET_C: preset_reg[2] <= cfg_wdata[ANGLE_W-1:0];
                REG_PRESET_D: preset_reg[3] <= cfg_wdata[ANGLE_W-1:0];
                REG_STARTUP:  startup_reg   <= cfg_wdata[ANGLE_W-1:0];
                REG_JOG_GAIN: gain_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_HOLD_MS:  hold_reg      <= cfg_wdata[HOLD_W-1:0];
                default:      ; // writes past the last register are dropped
            endcase
        end
    end

    assign cfg.preset_angle    = preset_reg;
    assign cfg.startup_angle   = startup_reg;
    assign cfg.release_hold_ms = hold_reg;

    // the jog step is formed ahead of the input register; the user must change
    // the gain only while the block is idle, which the block does not enforce
    assign product = joystick * $signed({1'b0, gain_reg});

    always_comb
    begin
        s0_next.now_ms         = now_ms;
        s0_next.jog_delta      = product[DELTA_W-1:0];
        s0_next.mode           = mode;
        s0_next.buttons        = buttons;
        s0_next.suction_switch = suction_switch;
        s0_next.preset_switch  = preset_switch;
    end

    assign in_stall = !(!s0_valid_reg || s0_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s0_reg <= s0_next;
        end
    end

    sjsc_core #(
        .NUM_SERVOS (NUM_SERVOS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (s0_valid_reg),
        .tick       (s0_reg),
        .cfg        (cfg),
        .tick_ready (s0_ready),
        .mid_ready  (mid_ready),
        .mid_valid  (mid_valid),
        .mid        (mid)
    );

    sjsc_pulse u_pulse (
        .clk          (clk),
        .rst_n        (rst_n),
        .mid_valid    (mid_valid),
        .mid          (mid),
        .mid_ready    (mid_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pulse_a      (pulse_a),
        .pulse_b      (pulse_b),
        .pulse_c      (pulse_c),
        .pulse_d      (pulse_d),
        .pump_on      (pump_on),
        .valve_open   (valve_open),
        .servo_sel    (servo_sel),
        .suction_flag (suction_flag)
    );

endmodule

`default_nettype wire
